// ===== hw/rtl/ghc_pkg.sv =====
// ghc_pkg: shared types and constants of the geneve header checker
// used by every module of the block and by its checker; no dependencies
`default_nettype none

package ghc_pkg;

    // width of the packet length counter (valid range 9 to 32)
    localparam int LENGTH_BITS = 16;
    localparam int CMP_W       = (LENGTH_BITS > 10) ? LENGTH_BITS : 10;
    localparam int EXT_W       = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam logic [8:0] HDR_MIN         = 9'd8;
    localparam logic [7:0] OPT_TOTAL_MASK  = 8'h3F;
    localparam logic [7:0] OPT_SINGLE_MASK = 8'h1F;

    localparam logic [2:0] VERDICT_OK       = 3'd0;
    localparam logic [2:0] VERDICT_DISABLED = 3'd1;
    localparam logic [2:0] VERDICT_TRUNC    = 3'd2;
    localparam logic [2:0] VERDICT_VERSION  = 3'd3;
    localparam logic [2:0] VERDICT_RESERVED = 3'd4;
    localparam logic [2:0] VERDICT_OPTLEN   = 3'd5;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_IPV4 = 2'd1;
    localparam logic [1:0] KIND_IPV6 = 2'd2;
    localparam logic [1:0] KIND_ETH  = 2'd3;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [15:0] ETYPE_ETH  = 16'h6558;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;

    localparam logic [2:0] REG_DECODER_ENABLED = 3'd0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [1:0]  inner_kind;
        logic        unknown_ethertype;
        logic [8:0]  inner_offset;
        logic [15:0] inner_length;
    } t_out_item;

    // per-packet summary handed from the front to the back
    typedef struct packed {
        logic                   enabled;
        logic [LENGTH_BITS-1:0] len;
        logic [7:0]             ver_optlen;
        logic [7:0]             flags;
        logic [15:0]            ether_type;
        logic [7:0]             rsvd;
        logic [8:0]             next_opt;
    } t_pkt_sum;

    function automatic logic [8:0] hdr_len(input logic [7:0] ver_optlen);
        return HDR_MIN + {1'b0, ver_optlen[5:0], 2'b00};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ghc_front.sv =====
// ghc_front: byte-serial header capture and option walk, one summary per packet
// depends on ghc_pkg
`default_nettype none

module ghc_front import ghc_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_item i_data,
    input  wire logic     i_enabled,
    input  wire logic     i_full,
    output logic          o_stall,
    output logic          o_push,
    output t_pkt_sum      o_sum
);

    localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;

    logic [LENGTH_BITS-1:0] r_pos, n_pos;
    logic [7:0]             r_vol, n_vol;
    logic [7:0]             r_flags, n_flags;
    logic [15:0]            r_etype, n_etype;
    logic [7:0]             r_rsvd, n_rsvd;
    logic [8:0]             r_nos, n_nos;

    logic       accept;
    logic [7:0] b;
    logic [8:0] hlen;
    logic       opt_hit;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign b       = i_data.data_byte;

    always_comb begin
        n_vol   = (r_pos == LENGTH_BITS'(0)) ? b : r_vol;
        n_flags = (r_pos == LENGTH_BITS'(1)) ? b : r_flags;
        n_etype = r_etype;
        if (r_pos == LENGTH_BITS'(2)) begin
            n_etype[15:8] = b;
        end
        if (r_pos == LENGTH_BITS'(3)) begin
            n_etype[7:0] = b;
        end
        n_rsvd = (r_pos == LENGTH_BITS'(7)) ? b : r_rsvd;

        hlen = hdr_len(n_vol);
        // length byte of the current option sits three bytes into it
        opt_hit = (CMP_W'(r_pos) >= CMP_W'(HDR_MIN)) && (r_nos < hlen) &&
                  (CMP_W'(r_pos) == CMP_W'(r_nos) + CMP_W'(3));
        n_nos = opt_hit ? (r_nos + 9'd4 + {2'b00, b[4:0] & OPT_SINGLE_MASK[4:0], 2'b00})
                        : r_nos;
        n_pos = (r_pos == CNT_MAX) ? r_pos : r_pos + LENGTH_BITS'(1);
    end

    assign o_push           = accept && i_data.last_byte;
    assign o_sum.enabled    = i_enabled;
    assign o_sum.len        = n_pos;
    assign o_sum.ver_optlen = n_vol;
    assign o_sum.flags      = n_flags;
    assign o_sum.ether_type = n_etype;
    assign o_sum.rsvd       = n_rsvd;
    assign o_sum.next_opt   = n_nos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_pos   <= '0;
            r_vol   <= '0;
            r_flags <= '0;
            r_etype <= '0;
            r_rsvd  <= '0;
            r_nos   <= HDR_MIN;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_vol   <= n_vol;
            r_flags <= n_flags;
            r_etype <= n_etype;
            r_rsvd  <= n_rsvd;
            r_nos   <= n_nos;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ghc_fifo.sv =====
// ghc_fifo: short queue of packet summaries between front and back
// depends on ghc_pkg
`default_nettype none

module ghc_fifo import ghc_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_pkt_sum i_sum,
    input  wire logic     i_pop,
    output logic          o_full,
    output logic          o_empty,
    output t_pkt_sum      o_head
);

    t_pkt_sum             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_AW:0]     r_cnt;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (FIFO_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (FIFO_AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ghc_back.sv =====
// ghc_back: verdict, ethertype class and inner offsets, into the output register
// depends on ghc_pkg
`default_nettype none

module ghc_back import ghc_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_pkt_sum i_head,
    input  wire logic     i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_out_item     o_data
);

    logic             r_valid;
    t_out_item        r_out;
    t_out_item        res;
    logic [8:0]       hlen;
    logic [EXT_W-1:0] len_ext;
    logic [EXT_W-1:0] diff;

    assign o_pop   = !i_empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_data  = r_out;

    always_comb begin
        hlen    = hdr_len(i_head.ver_optlen);
        len_ext = EXT_W'(i_head.len);
        diff    = len_ext - EXT_W'(hlen);
        res     = '0;

        if (!i_head.enabled) begin
            res.verdict = VERDICT_DISABLED;
        end else if (len_ext < EXT_W'(HDR_MIN) || len_ext < EXT_W'(hlen)) begin
            res.verdict = VERDICT_TRUNC;
        end else if (i_head.ver_optlen[7:6] != 2'b00) begin
            res.verdict = VERDICT_VERSION;
        end else if ((i_head.flags & OPT_TOTAL_MASK) != 8'h00 || i_head.rsvd != 8'h00) begin
            res.verdict = VERDICT_RESERVED;
        end else if (i_head.next_opt != hlen) begin
            res.verdict = VERDICT_OPTLEN;
        end else begin
            res.verdict = VERDICT_OK;
        end

        if (res.verdict == VERDICT_OK) begin
            unique case (i_head.ether_type)
                ETYPE_IPV4: res.inner_kind = KIND_IPV4;
                ETYPE_IPV6: res.inner_kind = KIND_IPV6;
                ETYPE_ETH:  res.inner_kind = KIND_ETH;
                ETYPE_ARP:  res.inner_kind = KIND_NONE;
                default: begin
                    res.inner_kind        = KIND_NONE;
                    res.unknown_ethertype = 1'b1;
                end
            endcase
            res.inner_offset = hlen;
            // saturate when the counter is wider than the output field
            res.inner_length = (diff > EXT_W'(16'hFFFF)) ? 16'hFFFF : diff[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= res;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/geneve_header_checker.sv =====
// geneve_header_checker: one byte per cycle in when not stalled, one verdict per packet out.
// the last byte's summary is written to the summary queue and loaded from its head into
// the output register, which then offers the verdict.
// throughput: one byte every cycle; the back end delivers one verdict per cycle unless
// stalled; a four-entry summary queue absorbs output stalls, input stalls only when full.
// reset: synchronous active low; clears packet state and queue, decoder_enabled to 1.
`default_nettype none

module geneve_header_checker import ghc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_in_item    i_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_out_item        o_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic     r_enabled;
    logic     cfg_wr;
    logic     full;
    logic     empty;
    logic     push;
    logic     pop;
    t_pkt_sum sum;
    t_pkt_sum head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b1;
        end else if (cfg_wr && paddr == REG_DECODER_ENABLED) begin
            r_enabled <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_DECODER_ENABLED) begin
            prdata[0] = r_enabled;
        end
    end

    ghc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_data    (i_data),
        .i_enabled (r_enabled),
        .i_full    (full),
        .o_stall   (o_stall),
        .o_push    (push),
        .o_sum     (sum)
    );

    ghc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_sum   (sum),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    ghc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ghc_checker.sv =====
// ghc_checker: port-level assertions for geneve_header_checker, bound to the top level
// depends on ghc_pkg
`default_nettype none

module ghc_checker import ghc_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire t_in_item    i_data,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire t_out_item   o_data,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);

    // a held result stays offered and unchanged
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result dropped or changed while stalled");

    // a stalled input transaction stays offered and unchanged
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_data))
        else $error("input dropped or changed while stalled");

    // failed verdicts carry no inner information
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.verdict != VERDICT_OK |->
            o_data.inner_kind == KIND_NONE && !o_data.unknown_ethertype &&
            o_data.inner_offset == 9'd0 && o_data.inner_length == 16'd0)
        else $error("inner fields set on failed verdict");

    // good packets: word-aligned header of eight bytes or more, no kind if type unknown
    a_ok_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.verdict == VERDICT_OK |->
            o_data.inner_offset >= HDR_MIN && o_data.inner_offset[1:0] == 2'b00 &&
            (!o_data.unknown_ethertype || o_data.inner_kind == KIND_NONE))
        else $error("bad inner offset or kind on good packet");

    // register write is visible on the following read
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && paddr == REG_DECODER_ENABLED |=>
            (paddr != REG_DECODER_ENABLED || prdata[0] == $past(pwdata[0])))
        else $error("decoder_enabled readback mismatch");

endmodule

bind geneve_header_checker ghc_checker u_ghc_checker (.*);

`default_nettype wire

// ===== tb/geneve_header_checker_tb.sv =====
// geneve_header_checker_tb: self-checking testbench for the geneve header checker
// sends byte streams with random gaps and output stalls and predicts each verdict in-line
// depends on ghc_pkg and the geneve_header_checker rtl

module geneve_header_checker_tb;
    import ghc_pkg::*;

    localparam int unsigned     CYCLE_LIMIT          = 2_000_000;
    localparam logic [2:0]      ADDR_DECODER_ENABLED = 3'(4 * REG_DECODER_ENABLED);
    localparam longint unsigned LEN_MAX              = (64'd1 << LENGTH_BITS) - 1;

    typedef enum int {RX_FREE, RX_SPARSE, RX_PERIODIC, RX_HEAVY} t_rx_mode;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    t_in_item    i_data  = '0;
    logic        i_stall = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic        o_stall;
    logic        o_valid;
    t_out_item   o_data;
    logic [31:0] prdata;
    logic        pready;

    geneve_header_checker DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state: one packet in flight plus the decoder enable
    longint unsigned pkt_len_seen   = 0;
    logic [7:0]      hdr_ver_optlen = '0;
    logic [7:0]      hdr_flags      = '0;
    logic [15:0]     hdr_ether_type = '0;
    logic [7:0]      hdr_rsvd       = '0;
    logic [8:0]      opt_cursor     = HDR_MIN;
    logic            decoder_on     = 1'b1;
    t_out_item       verdict_q[$];
    t_out_item       verdict_due;

    logic [7:0]  pkt[$];
    int          burst_left  = 0;
    bit          gaps_on     = 1'b1;
    int          bytes_sent  = 0;
    int          pkts_sent   = 0;
    int          longest_pkt = 0;
    int          n_ok        = 0;
    int          n_rejected  = 0;
    int          cfg_writes  = 0;
    int          fail_count  = 0;
    int unsigned cyc_count   = 0;
    t_rx_mode    rx_mode     = RX_FREE;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_packet_state();
        pkt_len_seen   = 0;
        hdr_ver_optlen = '0;
        hdr_flags      = '0;
        hdr_ether_type = '0;
        hdr_rsvd       = '0;
        opt_cursor     = HDR_MIN;
    endfunction

    function automatic void predict_verdict(input logic [7:0] b, input logic last);
        longint unsigned pos;
        longint unsigned len;
        logic [8:0]      hlen;
        t_out_item       res;
        pos = pkt_len_seen;
        if (pos == 0) hdr_ver_optlen = b;
        else if (pos == 1) hdr_flags = b;
        else if (pos == 2) hdr_ether_type[15:8] = b;
        else if (pos == 3) hdr_ether_type[7:0] = b;
        else if (pos == 7) hdr_rsvd = b;

        hlen = HDR_MIN + {1'b0, hdr_ver_optlen[5:0], 2'b00};
        // option length byte sits three bytes into each option
        if (pos >= HDR_MIN && opt_cursor < hlen && pos == opt_cursor + 3)
            opt_cursor = opt_cursor + 9'd4 + {2'b00, b[4:0], 2'b00};

        len = (pos < LEN_MAX) ? pos + 1 : LEN_MAX;
        pkt_len_seen = len;
        if (!last) return;

        res = '0;
        if (!decoder_on) res.verdict = VERDICT_DISABLED;
        else if (len < HDR_MIN || len < hlen) res.verdict = VERDICT_TRUNC;
        else if (hdr_ver_optlen[7:6] != 2'b00) res.verdict = VERDICT_VERSION;
        else if (hdr_flags[5:0] != 6'd0 || hdr_rsvd != 8'd0) res.verdict = VERDICT_RESERVED;
        else if (opt_cursor != hlen) res.verdict = VERDICT_OPTLEN;
        else res.verdict = VERDICT_OK;

        if (res.verdict == VERDICT_OK) begin
            case (hdr_ether_type)
                ETYPE_IPV4: res.inner_kind = KIND_IPV4;
                ETYPE_IPV6: res.inner_kind = KIND_IPV6;
                ETYPE_ETH:  res.inner_kind = KIND_ETH;
                ETYPE_ARP:  res.inner_kind = KIND_NONE;
                default:    res.unknown_ethertype = 1'b1;
            endcase
            res.inner_offset = hlen;
            if (len - hlen > 64'hFFFF) res.inner_length = 16'hFFFF;
            else res.inner_length = 16'(len - hlen);
        end
        verdict_q.push_back(res);
        clear_packet_state();
    endfunction

    function automatic void cmp_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (verdict_q.size() == 0) begin
                $error("verdict %0d arrived with no packet pending", o_data.verdict);
                fail_count++;
            end else begin
                verdict_due = verdict_q.pop_front();
                cmp_field("verdict", 32'(verdict_due.verdict), 32'(o_data.verdict));
                cmp_field("inner_kind", 32'(verdict_due.inner_kind),
                          32'(o_data.inner_kind));
                cmp_field("unknown_ethertype", 32'(verdict_due.unknown_ethertype),
                          32'(o_data.unknown_ethertype));
                cmp_field("inner_offset", 32'(verdict_due.inner_offset),
                          32'(o_data.inner_offset));
                cmp_field("inner_length", 32'(verdict_due.inner_length),
                          32'(o_data.inner_length));
                if (verdict_due.verdict == VERDICT_OK) n_ok++;
                else n_rejected++;
            end
        end
    end

    // receiver stall pattern, switched at random among four modes
    always @(posedge i_clk) begin
        cyc_count <= cyc_count + 1;
        if (cyc_count[7:0] == 8'd0) rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_FREE:     i_stall <= 1'b0;
            RX_SPARSE:   i_stall <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: i_stall <= (cyc_count[2:0] >= 3'd5);
            default:     i_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    initial begin
        wait (cyc_count >= CYCLE_LIMIT);
        $error("no completion after %0d cycles, %0d verdicts pending",
               cyc_count, verdict_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        i_valid <= 1'b1;
        i_data  <= '{data_byte: b, last_byte: last};
        do @(posedge i_clk); while (o_stall);
        predict_verdict(b, last);
        bytes_sent++;
        if (gaps_on) begin
            if (burst_left == 0) begin
                i_valid <= 1'b0;
                burst_left = $urandom_range(1, 20);
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_pkt();
        foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
        if (pkt.size() > longest_pkt) longest_pkt = pkt.size();
        pkts_sent++;
        pkt.delete();
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_DECODER_ENABLED;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_decoder_enabled(input logic en);
        logic [31:0] rd;
        wait_results_drained();
        apb_xfer(1'b1, {31'd0, en}, rd);
        decoder_on = en;
        cfg_writes++;
        apb_xfer(1'b0, 32'd0, rd);
        cmp_field("decoder_enabled readback", 32'(en), 32'(rd[0]));
    endtask

    function automatic void pkt_hdr(input logic [7:0] ver_optlen, input logic [7:0] flags,
                                    input logic [15:0] etype, input logic [7:0] rsvd);
        pkt.push_back(ver_optlen);
        pkt.push_back(flags);
        pkt.push_back(etype[15:8]);
        pkt.push_back(etype[7:0]);
        repeat (3) pkt.push_back(8'($urandom));
        pkt.push_back(rsvd);
    endfunction

    function automatic void pkt_opt(input logic [4:0] len5, input logic [2:0] top3);
        repeat (3) pkt.push_back(8'($urandom));
        pkt.push_back({top3, len5});
        repeat (4 * len5) pkt.push_back(8'($urandom));
    endfunction

    function automatic void pkt_payload(input int n);
        repeat (n) pkt.push_back(8'($urandom));
    endfunction

    // fills the option area; loose lets the last option run past the header end
    function automatic void pkt_opts(input int words, input bit loose);
        int left;
        int span;
        int len5;
        left = words;
        while (left > 0) begin
            span = loose ? left + 2 : left - 1;
            if (span > 31) span = 31;
            if ($urandom_range(0, 2) != 0 && span > 3) span = 3;
            len5 = $urandom_range(0, span);
            pkt_opt(5'(len5), 3'($urandom));
            left -= len5 + 1;
        end
    endfunction

    task automatic test_ethertypes();
        logic [15:0] etypes [5];
        etypes = '{ETYPE_IPV4, ETYPE_IPV6, ETYPE_ETH, ETYPE_ARP, 16'h1234};
        foreach (etypes[k]) begin
            pkt_hdr(8'h00, 8'h00, etypes[k], 8'h00);
            pkt_payload(k * 3);
            send_pkt();
        end
        // the two top flag bits are not reserved
        pkt_hdr(8'h00, 8'hC0, 16'hFFFF, 8'h00);
        send_pkt();
    endtask

    task automatic test_truncation();
        pkt.push_back(8'h00);
        send_pkt();
        pkt_hdr(8'h00, 8'h00, ETYPE_IPV4, 8'h00);
        void'(pkt.pop_back());
        send_pkt();
        // header says 16 bytes, only 15 arrive
        pkt_hdr(8'h02, 8'h00, ETYPE_IPV4, 8'h00);
        pkt_opt(5'd0, 3'd0);
        pkt_payload(3);
        send_pkt();
        pkt_hdr(8'h3F, 8'h00, ETYPE_IPV6, 8'h00);
        send_pkt();
        // truncation wins over bad version and reserved bits
        pkt_hdr(8'hC1, 8'h3F, ETYPE_IPV4, 8'hFF);
        send_pkt();
    endtask

    task automatic test_header_fields();
        pkt_hdr(8'h40, 8'h00, ETYPE_IPV4, 8'h00);
        send_pkt();
        pkt_hdr(8'hC0, 8'h00, ETYPE_ETH, 8'h00);
        send_pkt();
        pkt_hdr(8'h00, 8'h01, ETYPE_IPV4, 8'h00);
        send_pkt();
        pkt_hdr(8'h00, 8'h20, ETYPE_IPV6, 8'h00);
        send_pkt();
        pkt_hdr(8'h00, 8'h00, ETYPE_IPV4, 8'h80);
        send_pkt();
        pkt_hdr(8'h80, 8'h00, ETYPE_IPV4, 8'h01);
        send_pkt();
        // reserved flags checked before a bad option chain
        pkt_hdr(8'h01, 8'h02, ETYPE_IPV4, 8'h00);
        pkt_opt(5'd1, 3'd0);
        send_pkt();
    endtask

    task automatic test_options();
        pkt_hdr(8'h01, 8'h00, ETYPE_IPV4, 8'h00);
        pkt_opt(5'd0, 3'b111);
        pkt_payload(5);
        send_pkt();
        // largest header: 63 words of options
        pkt_hdr(8'h3F, 8'h00, ETYPE_IPV6, 8'h00);
        pkt_opt(5'd31, 3'b000);
        pkt_opt(5'd30, 3'b101);
        pkt_payload(2);
        send_pkt();
        pkt_hdr(8'h20, 8'hC0, ETYPE_ETH, 8'h00);
        pkt_opt(5'd31, 3'b111);
        send_pkt();
        pkt_hdr(8'h01, 8'h00, ETYPE_IPV4, 8'h00);
        pkt_opt(5'd1, 3'd0);
        send_pkt();
        pkt_hdr(8'h02, 8'h00, ETYPE_ARP, 8'h00);
        pkt_opt(5'd0, 3'd0);
        pkt_opt(5'd3, 3'd0);
        send_pkt();
    endtask

    task automatic test_disable();
        set_decoder_enabled(1'b0);
        pkt_hdr(8'h00, 8'h00, ETYPE_IPV4, 8'h00);
        pkt_payload(4);
        send_pkt();
        pkt.push_back(8'hFF);
        send_pkt();
        set_decoder_enabled(1'b1);
        pkt_hdr(8'h00, 8'h00, ETYPE_IPV6, 8'h00);
        send_pkt();
    endtask

    task automatic random_packet();
        int         optw;
        int         pick;
        int         flaw;
        int         keep;
        logic [15:0] etype;
        logic [7:0] ver;
        logic [7:0] flg;
        logic [7:0] rsv;
        pick = $urandom_range(0, 19);
        if (pick < 13) optw = $urandom_range(0, 3);
        else if (pick < 19) optw = $urandom_range(4, 16);
        else optw = $urandom_range(17, 63);
        case ($urandom_range(0, 4))
            0: etype = ETYPE_IPV4;
            1: etype = ETYPE_IPV6;
            2: etype = ETYPE_ETH;
            3: etype = ETYPE_ARP;
            default: etype = 16'($urandom);
        endcase
        // mostly well-formed, the rest carry one flaw
        flaw = ($urandom_range(0, 9) < 7) ? -1 : $urandom_range(0, 5);
        if (flaw == 3 && optw == 0) optw = 1;
        ver = {2'b00, 6'(optw)};
        flg = {2'($urandom), 6'd0};
        rsv = 8'd0;
        if (flaw == 0) ver[7:6] = 2'($urandom_range(1, 3));
        if (flaw == 1) flg[5:0] = 6'($urandom_range(1, 63));
        if (flaw == 2) rsv = 8'($urandom_range(1, 255));
        pkt_hdr(ver, flg, etype, rsv);
        pkt_opts(optw, flaw == 3);
        pkt_payload(($urandom_range(0, 4) == 0) ? $urandom_range(0, 150)
                                                : $urandom_range(0, 12));
        if (flaw == 4) begin
            keep = $urandom_range(1, pkt.size());
            while (pkt.size() > keep) void'(pkt.pop_back());
        end
        if (flaw == 5) begin
            pkt.delete();
            pkt_payload($urandom_range(1, 16));
        end
        send_pkt();
    endtask

    task automatic test_random();
        int budget [4];
        int ph;
        int start_bytes;
        int start_pkts;
        budget = '{120, 60, 120, 80};
        for (ph = 0; ph < 4; ph++) begin
            if (ph == 1) set_decoder_enabled(1'b0);
            else if (ph == 3) set_decoder_enabled(1'($urandom_range(0, 1)));
            else set_decoder_enabled(1'b1);
            start_bytes = bytes_sent;
            start_pkts  = pkts_sent;
            while (bytes_sent - start_bytes < budget[ph] || pkts_sent - start_pkts < 5) begin
                gaps_on = ($urandom_range(0, 4) != 0);
                random_packet();
                if ($urandom_range(0, 19) == 0) wait_results_drained();
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_ethertypes();
        test_truncation();
        test_header_fields();
        test_options();
        test_disable();
        test_random();
        wait_results_drained();
        $display("sent %0d packets in %0d bytes (longest %0d); %0d decoded ok, %0d rejected",
                 pkts_sent, bytes_sent, longest_pkt, n_ok, n_rejected);
        $display("decoder_enabled written %0d times, output stalled in four patterns",
                 cfg_writes);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
